/* hdl/job_sequencing_with_deadlines_defines.svh */
// Assertion macros shared by the job sequencing RTL.
`ifndef JOB_SEQUENCING_WITH_DEADLINES_DEFINES_SVH
`define JOB_SEQUENCING_WITH_DEADLINES_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define JSD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define JSD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/jsd_pkg.sv */
// Shared types and constants for the job sequencing block.
`timescale 1ns / 1ps
`default_nettype none
package jsd_pkg;

   localparam int ID_W   = 8;
   localparam int DL_W   = 6;
   localparam int PF_W   = 16;
   localparam int SUM_W  = 21;
   localparam int JOB_W  = ID_W + DL_W + PF_W;
   localparam int SLOT_W = ID_W + PF_W;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [2:0] {
      S_LOAD,
      S_SCAN_INIT,
      S_SCAN,
      S_PLACE,
      S_EMIT_INIT,
      S_EMIT_RD,
      S_EMIT_LD,
      S_NOSLOT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_en;
      logic scan_init;
      logic scan;
      logic pick;
      logic place;
      logic emit_init;
      logic emit_load;
      logic emit_none;
      logic clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_in;
      logic slots_full;
      logic scan_done;
      logic best_valid;
      logic place_done;
      logic no_slots;
      logic last_emit;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

/* hdl/job_sequencing_with_deadlines.sv */
// Top level of the greedy job sequencing with deadlines block.
`timescale 1ns / 1ps
`default_nettype none
// Loads one job per item into a job store RAM; the item with tlast
// closes the batch. Scheduling then runs passes over the store: each
// pass reads every stored job once through the RAM port to find the next
// job in profit order, then places it by stepping down from its deadline
// one slot per cycle. At most n jobs are picked, and picking ends early
// once every slot up to the largest deadline is full. Scheduling time
// grows with each occupied slot stepped over on the way down, and the
// single read port of the job store means each pass reads one job at a
// time. Results follow one per slot from slot 1 upward, each held until
// taken, with the running profit total; a batch whose deadlines are all 0
// gives one result with slot number 0. New jobs are taken again as soon as
// the last result sits in the output register.
module job_sequencing_with_deadlines
   import jsd_pkg::*;
#(
   parameter int MAX_JOBS  = 64,
   parameter int MAX_SLOTS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // job_id[7:0], deadline[13:8], profit[29:14], zero [31:30]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // slot_number[5:0], slot_used[6], placed_job_id[14:7], placed_profit[30:15],
   // profit_so_far[51:31], batch_overflow[52], zero [55:53]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   cmd_type cmd;
   sts_type sts;

   logic [DL_W-1:0]  out_slot;
   logic             out_used;
   logic [ID_W-1:0]  out_id;
   logic [PF_W-1:0]  out_pf;
   logic [SUM_W-1:0] out_sum;
   logic             out_ovf;

   jsd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   jsd_dp #(.MAX_JOBS(MAX_JOBS), .MAX_SLOTS(MAX_SLOTS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_valid (req_tvalid),
      .in_id     (req_tdata[7:0]),
      .in_dl     (req_tdata[13:8]),
      .in_pf     (req_tdata[29:14]),
      .in_last   (req_tlast),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .out_slot  (out_slot),
      .out_used  (out_used),
      .out_id    (out_id),
      .out_pf    (out_pf),
      .out_sum   (out_sum),
      .out_ovf   (out_ovf),
      .out_last  (rsp_tlast)
   );

   // Item packing.
   assign req_tready = cmd.load_en;
   assign rsp_tdata  = {3'b000, out_ovf, out_sum, out_pf, out_id, out_used, out_slot};

endmodule
`default_nettype wire

/* hdl/jsd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module jsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

/* hdl/jsd_ctrl.sv */
// Controller state machine for the job sequencing block.
`timescale 1ns / 1ps
`default_nettype none
module jsd_ctrl
   import jsd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_LOAD: begin
            cmd.load_en = 1'b1;
            if (sts.last_in) begin
               state_in = S_SCAN_INIT;
            end
         end
         S_SCAN_INIT: begin
            cmd.scan_init = 1'b1;
            if (sts.slots_full) begin
               state_in = S_EMIT_INIT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               if (sts.best_valid) begin
                  cmd.pick = 1'b1;
                  state_in = S_PLACE;
               end else begin
                  state_in = S_EMIT_INIT;
               end
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            if (sts.place_done) begin
               state_in = S_SCAN_INIT;
            end
         end
         S_EMIT_INIT: begin
            cmd.emit_init = 1'b1;
            if (sts.no_slots) begin
               state_in = S_NOSLOT;
            end else begin
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            if (sts.out_free) begin
               cmd.emit_load = 1'b1;
               if (sts.last_emit) begin
                  cmd.clear = 1'b1;
                  state_in  = S_LOAD;
               end else begin
                  state_in = S_EMIT_RD;
               end
            end
         end
         S_NOSLOT: begin
            if (sts.out_free) begin
               cmd.emit_none = 1'b1;
               cmd.clear     = 1'b1;
               state_in      = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

endmodule
`default_nettype wire

/* hdl/jsd_dp.sv */
// Datapath for the job sequencing block: job store, ranking scan, slot table and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "job_sequencing_with_deadlines_defines.svh"
module jsd_dp
   import jsd_pkg::*;
#(
   parameter int MAX_JOBS  = 64,
   parameter int MAX_SLOTS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   input  wire logic                  req_valid,
   input  wire logic [ID_W-1:0]       in_id,
   input  wire logic [DL_W-1:0]       in_dl,
   input  wire logic [PF_W-1:0]       in_pf,
   input  wire logic                  in_last,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic [DL_W-1:0]            out_slot,
   output logic                       out_used,
   output logic [ID_W-1:0]            out_id,
   output logic [PF_W-1:0]            out_pf,
   output logic [SUM_W-1:0]           out_sum,
   output logic                       out_ovf,
   output logic                       out_last
);

   localparam int CNT_W  = $clog2(MAX_JOBS + 1);
   localparam int IDX_W  = $clog2(MAX_JOBS);
   localparam int SIDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   // Batch state.
   logic [CNT_W-1:0] count_ff;
   logic [DL_W-1:0]  largest_ff;
   logic [DL_W-1:0]  filled_ff;
   logic             ovf_ff;
   logic [MAX_SLOTS-1:0] full_ff;

   // Ranking scan state.
   logic [CNT_W-1:0] cnt_ff;
   logic             rd_valid_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             have_prev_ff;
   logic [PF_W-1:0]  prev_pf_ff;
   logic [IDX_W-1:0] prev_idx_ff;
   logic             best_valid_ff;
   logic [PF_W-1:0]  best_pf_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [DL_W-1:0]  best_dl_ff;
   logic [ID_W-1:0]  best_id_ff;

   // Placement and emission state.
   logic [DL_W-1:0]  k_ff;
   logic [ID_W-1:0]  pick_id_ff;
   logic [PF_W-1:0]  pick_pf_ff;
   logic [DL_W-1:0]  s_ff;
   logic [SUM_W-1:0] sum_ff;

   logic             accept;
   logic             store_en;
   logic [DL_W-1:0]  in_dl_clamp;
   logic [JOB_W-1:0] job_rd;
   logic [ID_W-1:0]  rd_id;
   logic [DL_W-1:0]  rd_dl;
   logic [PF_W-1:0]  rd_pf;
   logic             eligible;
   logic             better;
   logic             issue;
   logic [SIDX_W-1:0] kidx;
   logic [SIDX_W-1:0] sidx;
   logic             k_taken;
   logic             k_free;
   logic [SLOT_W-1:0] slot_rd;
   logic [PF_W-1:0]  emit_pf;
   logic [ID_W-1:0]  emit_id;
   logic             emit_used;
   logic [SUM_W-1:0] new_sum;

   // Load side.
   assign accept      = req_valid && cmd.load_en;
   assign store_en    = accept && (count_ff != CNT_W'(MAX_JOBS));
   assign in_dl_clamp = ({1'b0, in_dl} > 7'(MAX_SLOTS)) ? DL_W'(MAX_SLOTS) : in_dl;

   jsd_ram #(.WIDTH(JOB_W), .DEPTH(MAX_JOBS), .AW(IDX_W)) u_job_ram (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({in_id, in_dl_clamp, in_pf}),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (job_rd)
   );

   assign rd_id = job_rd[JOB_W-1 -: ID_W];
   assign rd_dl = job_rd[PF_W +: DL_W];
   assign rd_pf = job_rd[PF_W-1:0];

   // Ranking: the next job is the best one ordered strictly after the previous pick.
   assign eligible = !have_prev_ff || (rd_pf < prev_pf_ff) ||
                     ((rd_pf == prev_pf_ff) && (rd_idx_ff > prev_idx_ff));
   assign better   = !best_valid_ff || (rd_pf > best_pf_ff);
   assign issue    = cmd.scan && (cnt_ff != count_ff);

   // Placement: walk down from the deadline to the latest free slot.
   assign kidx    = SIDX_W'(k_ff - DL_W'(1));
   assign k_taken = (k_ff != '0) && full_ff[kidx];
   assign k_free  = (k_ff != '0) && !full_ff[kidx];

   jsd_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS), .AW(SIDX_W)) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.place && k_free),
      .wr_addr (kidx),
      .wr_data ({pick_id_ff, pick_pf_ff}),
      .rd_addr (sidx),
      .rd_data (slot_rd)
   );

   // Emission values for the slot being reported.
   assign sidx      = SIDX_W'(s_ff - DL_W'(1));
   assign emit_used = full_ff[sidx];
   assign emit_id   = emit_used ? slot_rd[SLOT_W-1 -: ID_W] : '0;
   assign emit_pf   = emit_used ? slot_rd[PF_W-1:0] : '0;
   assign new_sum   = sum_ff + SUM_W'(emit_pf);

   // Batch registers.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff     <= '0;
         largest_ff   <= '0;
         filled_ff    <= '0;
         ovf_ff       <= 1'b0;
         full_ff      <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         if (store_en) begin
            count_ff <= count_ff + CNT_W'(1);
            if (in_dl_clamp > largest_ff) begin
               largest_ff <= in_dl_clamp;
            end
         end else if (accept) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.place && k_free) begin
            full_ff[kidx] <= 1'b1;
            filled_ff     <= filled_ff + DL_W'(1);
         end
         if (cmd.pick) begin
            have_prev_ff <= 1'b1;
         end
      end
   end

   // Scan pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else if (cmd.scan_init) begin
         rd_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         rd_valid_ff <= issue;
         if (issue) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (rd_valid_ff && eligible && better) begin
            best_valid_ff <= 1'b1;
         end
      end
   end

   // Scan and placement payload.
   always_ff @(posedge clock) begin
      rd_idx_ff <= cnt_ff[IDX_W-1:0];
      if (rd_valid_ff && eligible && better && !cmd.scan_init) begin
         best_pf_ff  <= rd_pf;
         best_idx_ff <= rd_idx_ff;
         best_dl_ff  <= rd_dl;
         best_id_ff  <= rd_id;
      end
      if (cmd.pick) begin
         prev_pf_ff  <= best_pf_ff;
         prev_idx_ff <= best_idx_ff;
         k_ff        <= best_dl_ff;
         pick_id_ff  <= best_id_ff;
         pick_pf_ff  <= best_pf_ff;
      end else if (cmd.place && k_taken) begin
         k_ff <= k_ff - DL_W'(1);
      end
      if (cmd.emit_init) begin
         s_ff   <= DL_W'(1);
         sum_ff <= '0;
      end else if (cmd.emit_load) begin
         s_ff   <= s_ff + DL_W'(1);
         sum_ff <= new_sum;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.emit_load || cmd.emit_none) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         out_slot <= s_ff;
         out_used <= emit_used;
         out_id   <= emit_id;
         out_pf   <= emit_pf;
         out_sum  <= new_sum;
         out_ovf  <= ovf_ff;
         out_last <= (s_ff == largest_ff);
      end else if (cmd.emit_none) begin
         out_slot <= '0;
         out_used <= 1'b0;
         out_id   <= '0;
         out_pf   <= '0;
         out_sum  <= '0;
         out_ovf  <= ovf_ff;
         out_last <= 1'b1;
      end
   end

   // Status to the controller.
   always_comb begin
      sts            = '0;
      sts.last_in    = accept && in_last;
      sts.slots_full = (filled_ff == largest_ff);
      sts.scan_done  = (cnt_ff == count_ff) && !rd_valid_ff;
      sts.best_valid = best_valid_ff;
      sts.place_done = (k_ff == '0) || !full_ff[kidx];
      sts.no_slots   = (largest_ff == '0);
      sts.last_emit  = (s_ff == largest_ff);
      sts.out_free   = !rsp_valid || rsp_ready;
   end

   `JSD_ASSERT_NOW(a_filled_bound, 1'b1, filled_ff <= largest_ff, "more slots filled than exist")
   `JSD_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(MAX_JOBS), "job count past capacity")
   `JSD_ASSERT_NEXT(a_clear_batch, cmd.clear, (count_ff == '0) && (full_ff == '0),
                    "batch not cleared after last result")
   `JSD_ASSERT_NOW(a_place_free, cmd.place && k_free, filled_ff != largest_ff,
                   "placement attempted with all slots full")

endmodule
`default_nettype wire
